/* rtl/core/sct_pkg.sv */
// ----------------------------------------------------------------------------
// sct_pkg: shared types, constants and helpers for the source tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int OFFSET_BITS = 16;

    localparam logic [3:0] M_IDLE   = 4'd0;
    localparam logic [3:0] M_WORD   = 4'd1;
    localparam logic [3:0] M_INT    = 4'd2;
    localparam logic [3:0] M_INTDOT = 4'd3;
    localparam logic [3:0] M_FLOAT  = 4'd4;
    localparam logic [3:0] M_STR    = 4'd5;
    localparam logic [3:0] M_STRESC = 4'd6;
    localparam logic [3:0] M_OP     = 4'd7;

    localparam logic [5:0] K_ID    = 6'd0;
    localparam logic [5:0] K_INT   = 6'd1;
    localparam logic [5:0] K_FLOAT = 6'd2;
    localparam logic [5:0] K_STR   = 6'd3;
    localparam logic [5:0] K_EOF   = 6'd4;
    localparam logic [5:0] K_NL    = 6'd5;
    localparam logic [5:0] K_DOT   = 6'd21;

    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_UNTERM = 2'd1;
    localparam logic [1:0] E_INVAL = 2'd2;

    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_BSL   = 8'h5C;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_UND   = 8'h5F;
    localparam logic [7:0] C_NL    = 8'h0A;

    typedef struct packed {
        logic [7:0] ch;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start_offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [1:0]  error_code;
        logic        run_end;
        logic        stream_done;
    } out_word_t;

    typedef struct packed {
        logic [1:0] cnt;
        out_word_t  r0;
        out_word_t  r1;
        out_word_t  r2;
    } bundle_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        k = 6'd0;
        case (c)
            8'h2B: k = 6'd6;
            8'h2D: k = 6'd8;
            8'h2A: k = 6'd10;
            8'h2F: k = 6'd11;
            8'h25: k = 6'd12;
            8'h26: k = 6'd13;
            8'h7C: k = 6'd14;
            8'h7B: k = 6'd15;
            8'h7D: k = 6'd16;
            8'h28: k = 6'd17;
            8'h29: k = 6'd18;
            8'h5B: k = 6'd19;
            8'h5D: k = 6'd20;
            8'h2E: k = 6'd21;
            8'h2C: k = 6'd22;
            8'h3B: k = 6'd23;
            8'h5F: k = 6'd24;
            8'h3F: k = 6'd25;
            8'h3D: k = 6'd27;
            8'h3C: k = 6'd30;
            8'h3E: k = 6'd33;
            8'h21: k = 6'd36;
            8'h3A: k = 6'd38;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    function automatic logic needs_look(input logic [7:0] c);
        return c == 8'h2B || c == 8'h2D || c == 8'h3F || c == 8'h3D || c == 8'h3C ||
               c == 8'h3E || c == 8'h21 || c == 8'h3A;
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] k;
        k = 6'd0;
        if (a == 8'h2B && b == 8'h2B) k = 6'd7;
        if (a == 8'h2D && b == 8'h2D) k = 6'd9;
        if (a == 8'h3F && b == 8'h2E) k = 6'd26;
        if (a == 8'h3D && b == 8'h3D) k = 6'd28;
        if (a == 8'h3D && b == 8'h3E) k = 6'd29;
        if (a == 8'h3C && b == 8'h3D) k = 6'd31;
        if (a == 8'h3C && b == 8'h3C) k = 6'd32;
        if (a == 8'h3E && b == 8'h3D) k = 6'd34;
        if (a == 8'h3E && b == 8'h3E) k = 6'd35;
        if (a == 8'h21 && b == 8'h3D) k = 6'd37;
        if (a == 8'h3A && b == 8'h3A) k = 6'd39;
        return k;
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {15'd0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

/* rtl/core/sct_if.sv */
// ----------------------------------------------------------------------------
// sct_if: valid/ready channels carrying one input or one token word.
// ----------------------------------------------------------------------------
interface sct_in_if;
    import sct_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sct_out_if;
    import sct_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/sct_scan.sv */
// ----------------------------------------------------------------------------
// sct_scan: scanner state and per-byte token logic.
// Consumes one byte per advance and produces up to three result words.
// ----------------------------------------------------------------------------
module sct_scan
    import sct_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  in_word_t in_word,
    output bundle_t  bundle
);

    logic [3:0]             mode_reg, mode_next;
    logic [7:0]             held_reg, held_next;
    logic [OFFSET_BITS-1:0] tstart_reg, tstart_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [15:0]            line_reg, line_next;
    logic                   err_reg, err_next;
    logic [15:0]            len_reg, len_next;

    logic [7:0]  c;
    logic        fin, used, err;
    logic [5:0]  pk;
    logic [1:0]  n;
    out_word_t   o [3];
    logic [15:0] line_emit;

    function automatic out_word_t mk(input logic [5:0] k, input logic [OFFSET_BITS-1:0] s,
                                     input logic [15:0] l, input logic [15:0] ln,
                                     input logic [1:0] e);
        out_word_t w;
        w.kind = k;
        w.start_offset = 16'(s);
        w.length = l;
        w.line = ln;
        w.error_code = e;
        w.run_end = 1'b0;
        w.stream_done = (e != E_NONE);
        return w;
    endfunction

    always_comb
    begin
        c = in_word.ch;
        fin = in_word.final_byte;
        mode_next = mode_reg;
        held_next = held_reg;
        tstart_next = tstart_reg;
        pos_next = pos_reg;
        line_next = line_reg;
        err_next = err_reg;
        len_next = len_reg;
        used = 1'b0;
        err = 1'b0;
        n = 2'd0;
        line_emit = line_reg;
        pk = pair_kind(held_reg, c);
        for (int i = 0; i < 3; i++)
        begin
            o[i] = '0;
        end

        if (err_reg)
        begin
            if (fin)
            begin
                mode_next = M_IDLE;
                held_next = '0;
                tstart_next = '0;
                pos_next = '0;
                line_next = 16'd1;
                err_next = 1'b0;
                len_next = '0;
            end
        end
        else
        begin
            case (mode_reg)
                M_WORD:
                    if (is_letter(c) || is_digit(c) || c == C_UND)
                    begin
                        len_next = sat_add(len_reg, 2'd1);
                        used = 1'b1;
                    end
                    else
                    begin
                        o[0] = mk(K_ID, tstart_reg, len_reg, line_emit, E_NONE);
                        n = 2'd1;
                        mode_next = M_IDLE;
                    end
                M_INT:
                    if (is_digit(c))
                    begin
                        len_next = sat_add(len_reg, 2'd1);
                        used = 1'b1;
                    end
                    else if (c == C_DOT)
                    begin
                        mode_next = M_INTDOT;
                        used = 1'b1;
                    end
                    else
                    begin
                        o[0] = mk(K_INT, tstart_reg, len_reg, line_emit, E_NONE);
                        n = 2'd1;
                        mode_next = M_IDLE;
                    end
                M_INTDOT:
                    if (is_digit(c))
                    begin
                        len_next = sat_add(len_reg, 2'd2);
                        mode_next = M_FLOAT;
                        used = 1'b1;
                    end
                    else
                    begin
                        o[0] = mk(K_INT, tstart_reg, len_reg, line_emit, E_NONE);
                        o[1] = mk(K_DOT, pos_reg - 1'b1, 16'd1, line_emit, E_NONE);
                        n = 2'd2;
                        mode_next = M_IDLE;
                    end
                M_FLOAT:
                    if (is_digit(c))
                    begin
                        len_next = sat_add(len_reg, 2'd1);
                        used = 1'b1;
                    end
                    else
                    begin
                        o[0] = mk(K_FLOAT, tstart_reg, len_reg, line_emit, E_NONE);
                        n = 2'd1;
                        mode_next = M_IDLE;
                    end
                M_STR:
                begin
                    len_next = sat_add(len_reg, 2'd1);
                    used = 1'b1;
                    if (c == C_QUOTE)
                    begin
                        o[0] = mk(K_STR, tstart_reg, len_next, line_emit, E_NONE);
                        n = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (c == C_BSL)
                    begin
                        mode_next = M_STRESC;
                    end
                end
                M_STRESC:
                begin
                    len_next = sat_add(len_reg, 2'd1);
                    used = 1'b1;
                    if (c != C_BSL)
                    begin
                        mode_next = M_STR;
                    end
                end
                M_OP:
                begin
                    if (pk != 6'd0)
                    begin
                        o[0] = mk(pk, tstart_reg, 16'd2, line_emit, E_NONE);
                        used = 1'b1;
                    end
                    else
                    begin
                        o[0] = mk(single_kind(held_reg), tstart_reg, 16'd1, line_emit, E_NONE);
                    end
                    n = 2'd1;
                    mode_next = M_IDLE;
                end
                default: mode_next = M_IDLE;
            endcase

            if (!used)
            begin
                if (is_blank(c))
                begin
                end
                else if (is_letter(c) || is_digit(c) || c == C_QUOTE)
                begin
                    mode_next = is_letter(c) ? M_WORD : (is_digit(c) ? M_INT : M_STR);
                    tstart_next = pos_reg;
                    len_next = 16'd1;
                end
                else if (needs_look(c))
                begin
                    mode_next = M_OP;
                    held_next = c;
                    tstart_next = pos_reg;
                end
                else if (c == C_NL)
                begin
                    o[n] = mk(K_NL, pos_reg, 16'd1, line_emit, E_NONE);
                    n = n + 2'd1;
                    line_next = sat_add(line_reg, 2'd1);
                end
                else if (c == 8'd0)
                begin
                    o[n] = mk(K_EOF, pos_reg, 16'd1, line_emit, E_NONE);
                    n = n + 2'd1;
                end
                else if (single_kind(c) != 6'd0)
                begin
                    o[n] = mk(single_kind(c), pos_reg, 16'd1, line_emit, E_NONE);
                    n = n + 2'd1;
                end
                else
                begin
                    o[n] = mk(K_ID, pos_reg, 16'd0, line_emit, E_INVAL);
                    n = n + 2'd1;
                    err = 1'b1;
                end
            end

            // final flush uses the post-newline line count
            if (!err && fin)
            begin
                case (mode_next)
                    M_WORD:
                    begin
                        o[n] = mk(K_ID, tstart_next, len_next, line_next, E_NONE);
                        n = n + 2'd1;
                    end
                    M_INT:
                    begin
                        o[n] = mk(K_INT, tstart_next, len_next, line_next, E_NONE);
                        n = n + 2'd1;
                    end
                    M_INTDOT:
                    begin
                        o[n] = mk(K_INT, tstart_next, len_next, line_next, E_NONE);
                        o[n + 2'd1] = mk(K_DOT, pos_reg, 16'd1, line_next, E_NONE);
                        n = n + 2'd2;
                    end
                    M_FLOAT:
                    begin
                        o[n] = mk(K_FLOAT, tstart_next, len_next, line_next, E_NONE);
                        n = n + 2'd1;
                    end
                    M_STR, M_STRESC:
                    begin
                        o[n] = mk(K_ID, tstart_next, 16'd0, line_next, E_UNTERM);
                        n = n + 2'd1;
                    end
                    M_OP:
                    begin
                        o[n] = mk(single_kind(held_next), tstart_next, 16'd1, line_next,
                                  E_NONE);
                        n = n + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
                if (n == 2'd0)
                begin
                    o[0] = mk(K_EOF, pos_reg + 1'b1, 16'd0, line_next, E_NONE);
                    n = 2'd1;
                end
                o[n - 2'd1].stream_done = 1'b1;
            end

            if (n != 2'd0)
            begin
                o[n - 2'd1].run_end = 1'b1;
            end

            if (fin)
            begin
                mode_next = M_IDLE;
                held_next = '0;
                tstart_next = '0;
                pos_next = '0;
                line_next = 16'd1;
                err_next = 1'b0;
                len_next = '0;
            end
            else if (err)
            begin
                mode_next = M_IDLE;
                err_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end

        bundle.cnt = n;
        bundle.r0 = o[0];
        bundle.r1 = o[1];
        bundle.r2 = o[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            held_reg <= '0;
            tstart_reg <= '0;
            pos_reg <= '0;
            line_reg <= 16'd1;
            err_reg <= 1'b0;
            len_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            tstart_reg <= tstart_next;
            pos_reg <= pos_next;
            line_reg <= line_next;
            err_reg <= err_next;
            len_reg <= len_next;
        end
    end

endmodule

/* rtl/core/sct_drain.sv */
// ----------------------------------------------------------------------------
// sct_drain: result register that holds up to three words and sends
// them one per cycle while ready is high.
// ----------------------------------------------------------------------------
module sct_drain
    import sct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  bundle_t   bundle,
    output logic      empty_next,
    output logic      valid,
    input  logic      ready,
    output out_word_t data
);

    logic [1:0] cnt_reg, cnt_next;
    out_word_t  w0_reg, w1_reg, w2_reg;
    logic       pop;

    assign valid = (cnt_reg != 2'd0);
    assign data = w0_reg;
    assign pop = valid && ready;
    // drains fully this cycle, so a new bundle may load
    assign empty_next = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && ready);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = bundle.cnt;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            w0_reg <= bundle.r0;
            w1_reg <= bundle.r1;
            w2_reg <= bundle.r2;
        end
        else if (pop)
        begin
            w0_reg <= w1_reg;
            w1_reg <= w2_reg;
        end
    end

endmodule

/* rtl/core/source_code_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_code_tokenizer: streaming lexer, one source byte per word in,
// one token per word out.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_ch     in   ch, final_byte
//  out_ch    out  kind, start_offset, length, line, error_code, run_end,
//                 stream_done
//
// A byte is taken whenever the result register is empty or drains this
// cycle; while out_ch is ready, bytes giving one or no token stream at one
// per clock, tokens leaving one per cycle. A byte's first token is offered
// the cycle after it is taken; a byte with more holds input until all leave.
// Async reset returns to line 1, offset 0. Output stalls back up to input.
module source_code_tokenizer
    import sct_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    sct_in_if.sink     in_ch,
    sct_out_if.source  out_ch
);

    bundle_t bundle;
    logic    empty_next;
    logic    advance;

    assign in_ch.ready = empty_next;
    assign advance = in_ch.valid && in_ch.ready;

    sct_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_word (in_ch.data),
        .bundle  (bundle)
    );

    sct_drain u_drain (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .bundle     (bundle),
        .empty_next (empty_next),
        .valid      (out_ch.valid),
        .ready      (out_ch.ready),
        .data       (out_ch.data)
    );

`ifndef SYNTHESIS
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.error_code != E_NONE |-> out_ch.data.stream_done
        && out_ch.data.run_end)
        else $error("error word without end flags");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.stream_done |-> out_ch.data.run_end)
        else $error("stream_done without run_end");
    a_ready_tail: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready && out_ch.valid |-> out_ch.data.run_end)
        else $error("input taken before run drained");
`endif

endmodule
